// ----- src/assert_macros.svh -----
// Assertion macros for the RTL files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- src/tsbr_pkg.sv -----
// Constants and types of the triangle span rasterizer
package tsbr_pkg;
	localparam int MAX_ROWS   = 1024;
	localparam int ROW_AW     = $clog2(MAX_ROWS);
	localparam int CNT_W      = ROW_AW + 1;
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int WGT_W      = FRAC_BITS + 1;
	localparam int PROD_W     = 28;
	localparam int SPAN_W     = 2 * COORD_BITS;
	localparam int CFG_W      = 11;
	localparam int DIVC_W     = $clog2(FRAC_BITS + 1);

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_NEXT  = 1'b1;
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic [WGT_W-1:0] ONE_FX = WGT_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vy3;
		logic signed [COORD_BITS-1:0] vx3;
		logic signed [COORD_BITS-1:0] vy2;
		logic signed [COORD_BITS-1:0] vx2;
		logic signed [COORD_BITS-1:0] vy1;
		logic signed [COORD_BITS-1:0] vx1;
	} vertex_set_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic                         last;
	} edge_pos_t;
endpackage

// ----- src/tsbr_ram.sv -----
// Generic single-port-write, registered-read RAM
module tsbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- src/tsbr_edge.sv -----
// Bresenham edge stepper
module tsbr_edge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic                              step,
	input  logic signed [tsbr_pkg::COORD_BITS-1:0] x0,
	input  logic signed [tsbr_pkg::COORD_BITS-1:0] y0,
	input  logic signed [tsbr_pkg::COORD_BITS-1:0] x1,
	input  logic signed [tsbr_pkg::COORD_BITS-1:0] y1,
	output tsbr_pkg::edge_pos_t                pos
);
	import tsbr_pkg::*;

	logic signed [COORD_BITS-1:0] x_q, y_q, xe_q, ye_q;
	logic signed [COORD_BITS+1:0] dx_q, dy_q;
	logic signed [COORD_BITS+2:0] err_q;
	logic                         sx_q, sy_q;
	logic signed [COORD_BITS:0]   ddx, ddy;
	logic signed [COORD_BITS+1:0] adx, ady;
	logic signed [COORD_BITS+3:0] e2;
	logic                         mv_x, mv_y;

	always_comb begin
		ddx  = (COORD_BITS+1)'(x1) - (COORD_BITS+1)'(x0);
		ddy  = (COORD_BITS+1)'(y1) - (COORD_BITS+1)'(y0);
		adx  = ddx[COORD_BITS] ? -(COORD_BITS+2)'(ddx) : (COORD_BITS+2)'(ddx);
		ady  = ddy[COORD_BITS] ? -(COORD_BITS+2)'(ddy) : (COORD_BITS+2)'(ddy);
		e2   = (COORD_BITS+4)'(err_q) <<< 1;
		mv_x = e2 >= (COORD_BITS+4)'(dy_q);
		mv_y = e2 <= (COORD_BITS+4)'(dx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			xe_q  <= '0;
			ye_q  <= '0;
			dx_q  <= '0;
			dy_q  <= '0;
			err_q <= '0;
			sx_q  <= 1'b0;
			sy_q  <= 1'b0;
		end else if (load) begin
			x_q   <= x0;
			y_q   <= y0;
			xe_q  <= x1;
			ye_q  <= y1;
			dx_q  <= adx;
			dy_q  <= -ady;
			err_q <= (COORD_BITS+3)'(adx) - (COORD_BITS+3)'(ady);
			sx_q  <= x0 < x1;
			sy_q  <= y0 < y1;
		end else if (step) begin
			if (mv_x) begin
				x_q <= sx_q ? x_q + COORD_BITS'(1) : x_q - COORD_BITS'(1);
			end
			if (mv_y) begin
				y_q <= sy_q ? y_q + COORD_BITS'(1) : y_q - COORD_BITS'(1);
			end
			err_q <= err_q + (mv_x ? (COORD_BITS+3)'(dy_q) : '0)
				+ (mv_y ? (COORD_BITS+3)'(dx_q) : '0);
		end
	end

	assign pos.x    = x_q;
	assign pos.y    = y_q;
	assign pos.last = (x_q == xe_q) && (y_q == ye_q);
endmodule

// ----- src/tsbr_div.sv -----
// Clamped fixed-point weight divider, one quotient bit per cycle
module tsbr_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [tsbr_pkg::PROD_W-1:0] num,
	input  logic signed [tsbr_pkg::PROD_W-1:0] den,
	output logic                               busy,
	output logic [tsbr_pkg::WGT_W-1:0]         quo
);
	import tsbr_pkg::*;

	logic [PROD_W-1:0] na, da, rem_q, dv_q, sh;
	logic [DIVC_W-1:0] cnt_q;
	logic [WGT_W-1:0]  quo_q;
	logic              busy_q;

	always_comb begin
		na = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
		da = den[PROD_W-1] ? PROD_W'(-den) : PROD_W'(den);
		sh = {rem_q[PROD_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dv_q   <= '0;
		end else if (start) begin
			quo_q <= '0;
			if (num == '0 || num[PROD_W-1] != den[PROD_W-1]) begin
				busy_q <= 1'b0;
			end else if (na >= da) begin
				quo_q  <= ONE_FX;
				busy_q <= 1'b0;
			end else begin
				rem_q  <= na;
				dv_q   <= da;
				cnt_q  <= DIVC_W'(FRAC_BITS);
				busy_q <= 1'b1;
			end
		end else if (busy_q) begin
			if (sh >= dv_q) begin
				rem_q <= sh - dv_q;
				quo_q <= {quo_q[WGT_W-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				quo_q <= {quo_q[WGT_W-2:0], 1'b0};
			end
			cnt_q <= cnt_q - DIVC_W'(1);
			if (cnt_q == DIVC_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule

// ----- src/triangle_span_barycentric_raster.sv -----
// Top level: span table fill by edge walk, then pixel emission with weights
// Start beat: determinant, R rows cleared (R = min(height, 1024)), each edge walked with a
//   read and write per in-screen pixel, rows scanned; no walk when Det or R is zero.
// Next beat: weight products, the 16-step weight dividers, then a scan of the rows below
//   once a span ends; answers with no pixel when none are left.
// Reset: no triangle loaded, every next beat answers with no pixel.
module triangle_span_barycentric_raster (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // vx1, vy1, vx2, vy2, vx3, vy3
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // pixel_x, pixel_y, weight_a, weight_b, weight_c, zero pad
	output logic        m_tuser,   // pixel_valid
	output logic        m_tlast,   // last_pixel
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);
	import tsbr_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DET1  = 4'd1;
	localparam logic [3:0] ST_DET2  = 4'd2;
	localparam logic [3:0] ST_CLEAR = 4'd3;
	localparam logic [3:0] ST_ELOAD = 4'd4;
	localparam logic [3:0] ST_ERD   = 4'd5;
	localparam logic [3:0] ST_EWR   = 4'd6;
	localparam logic [3:0] ST_SKRD  = 4'd7;
	localparam logic [3:0] ST_SKCHK = 4'd8;
	localparam logic [3:0] ST_P1    = 4'd9;
	localparam logic [3:0] ST_P2    = 4'd10;
	localparam logic [3:0] ST_P3    = 4'd11;
	localparam logic [3:0] ST_DIVS  = 4'd12;
	localparam logic [3:0] ST_DIVW  = 4'd13;
	localparam logic [3:0] ST_OUT   = 4'd14;

	localparam int CW = COORD_BITS + 1;

	logic [3:0]               state_q;
	logic [CFG_W-1:0]         width_q, height_q;
	vertex_set_t              vert_q;
	logic signed [PROD_W-1:0] det_q, p1_q, p2_q;
	logic signed [2*CW-1:0]   prod_a_s1, prod_b_s1;
	logic [CNT_W-1:0]         cur_row_q, seek_row_q, clr_q;
	logic signed [COORD_BITS-1:0] cur_col_q, cur_right_q;
	logic signed [CW-1:0]     seek_col_q;
	logic                     seek_first_q, seek_pix_q, emit_done_q;
	logic [1:0]               edge_sel_q;
	logic signed [COORD_BITS-1:0] pix_x_q;
	logic [ROW_AW-1:0]        pix_y_q;
	logic [WGT_W-1:0]         wa_q, wb_q;
	logic                     out_pix_q, out_last_q;

	logic [CNT_W-1:0]         rows;
	logic signed [CW-1:0]     ma, mb, mc, md;
	logic signed [PROD_W-1:0] psum;
	logic                     ram_we;
	logic [ROW_AW-1:0]        ram_waddr, ram_raddr;
	logic [SPAN_W-1:0]        ram_wdata, ram_rdata;
	logic signed [COORD_BITS-1:0] rd_left, rd_right;
	logic signed [COORD_BITS-1:0] ex0, ey0, ex1, ey1;
	edge_pos_t                epos;
	logic                     e_load, e_step, y_ok;
	logic signed [CW-1:0]     c_eff, nx;
	logic                     sk_hit;
	logic                     div_start, busy_a, busy_b;
	logic [WGT_W-1:0]         qa, qb;
	logic signed [WGT_W:0]    wc_full;
	logic [WGT_W-1:0]         wc;
	logic                     out_free, accept;

	assign rows     = (height_q > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : height_q;
	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign rd_left  = ram_rdata[SPAN_W-1:COORD_BITS];
	assign rd_right = ram_rdata[COORD_BITS-1:0];

	always_comb begin
		unique case (state_q)
			ST_P1: begin
				ma = CW'(vert_q.vy2) - CW'(vert_q.vy3);
				mb = CW'(cur_col_q) - CW'(vert_q.vx3);
				mc = CW'(vert_q.vx3) - CW'(vert_q.vx2);
				md = CW'({1'b0, cur_row_q}) - CW'(vert_q.vy3);
			end
			ST_P2: begin
				ma = CW'(vert_q.vy3) - CW'(vert_q.vy1);
				mb = CW'(cur_col_q) - CW'(vert_q.vx3);
				mc = CW'(vert_q.vx1) - CW'(vert_q.vx3);
				md = CW'({1'b0, cur_row_q}) - CW'(vert_q.vy3);
			end
			default: begin
				ma = CW'(vert_q.vy2) - CW'(vert_q.vy3);
				mb = CW'(vert_q.vx1) - CW'(vert_q.vx3);
				mc = CW'(vert_q.vx3) - CW'(vert_q.vx2);
				md = CW'(vert_q.vy1) - CW'(vert_q.vy3);
			end
		endcase
		psum = PROD_W'(prod_a_s1) + PROD_W'(prod_b_s1);
	end

	always_comb begin
		unique case (edge_sel_q)
			2'd0: begin
				ex0 = vert_q.vx1; ey0 = vert_q.vy1; ex1 = vert_q.vx3; ey1 = vert_q.vy3;
			end
			2'd1: begin
				ex0 = vert_q.vx1; ey0 = vert_q.vy1; ex1 = vert_q.vx2; ey1 = vert_q.vy2;
			end
			default: begin
				ex0 = vert_q.vx2; ey0 = vert_q.vy2; ex1 = vert_q.vx3; ey1 = vert_q.vy3;
			end
		endcase
	end

	assign y_ok   = !epos.y[COORD_BITS-1] && (epos.y[CNT_W-1:0] < rows);
	assign e_load = state_q == ST_ELOAD;
	assign e_step = ((state_q == ST_ERD && !y_ok) || state_q == ST_EWR) && !epos.last;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q[ROW_AW-1:0];
		ram_wdata = {COORD_BITS'(width_q), COORD_BITS'(0)};
		ram_raddr = epos.y[ROW_AW-1:0];
		case (state_q)
			ST_CLEAR: ram_we = 1'b1;
			ST_EWR: begin
				ram_we    = 1'b1;
				ram_waddr = epos.y[ROW_AW-1:0];
				ram_wdata = {(epos.x < rd_left) ? epos.x : rd_left,
					(epos.x > rd_right) ? epos.x : rd_right};
			end
			ST_SKRD: ram_raddr = seek_row_q[ROW_AW-1:0];
			default: ;
		endcase
	end

	always_comb begin
		if (seek_first_q || seek_col_q < CW'(rd_left)) begin
			c_eff = CW'(rd_left);
		end else begin
			c_eff = seek_col_q;
		end
		sk_hit  = (rd_left <= rd_right) && (c_eff <= CW'(rd_right));
		nx      = CW'(cur_col_q) + CW'(1);
		wc_full = (WGT_W+1)'(ONE_FX) - (WGT_W+1)'(wa_q) - (WGT_W+1)'(wb_q);
		wc      = (wc_full[WGT_W] || !out_pix_q) ? '0 : wc_full[WGT_W-1:0];
	end

	assign div_start = state_q == ST_DIVS;

	tsbr_ram #(.WIDTH(SPAN_W), .DEPTH(MAX_ROWS)) u_span (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tsbr_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (e_load),
		.step   (e_step),
		.x0     (ex0),
		.y0     (ey0),
		.x1     (ex1),
		.y1     (ey1),
		.pos    (epos)
	);

	tsbr_div u_div_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (p1_q),
		.den    (det_q),
		.busy   (busy_a),
		.quo    (qa)
	);

	tsbr_div u_div_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (p2_q),
		.den    (det_q),
		.busy   (busy_b),
		.quo    (qb)
	);

	always_ff @(posedge clk) begin
		prod_a_s1 <= ma * mb;
		prod_b_s1 <= mc * md;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(640);
			height_q <= CFG_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vert_q       <= '0;
			det_q        <= '0;
			p1_q         <= '0;
			p2_q         <= '0;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			cur_right_q  <= '0;
			seek_row_q   <= '0;
			seek_col_q   <= '0;
			seek_first_q <= 1'b1;
			seek_pix_q   <= 1'b0;
			clr_q        <= '0;
			edge_sel_q   <= '0;
			emit_done_q  <= 1'b1;
			pix_x_q      <= '0;
			pix_y_q      <= '0;
			wa_q         <= '0;
			wb_q         <= '0;
			out_pix_q    <= 1'b0;
			out_last_q   <= 1'b0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= 1'b0;
			m_tlast      <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_OUT) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == CMD_START) begin
							vert_q  <= vertex_set_t'(s_tdata);
							state_q <= ST_DET1;
						end else if (emit_done_q) begin
							out_pix_q  <= 1'b0;
							out_last_q <= 1'b0;
							pix_x_q    <= '0;
							pix_y_q    <= '0;
							wa_q       <= '0;
							wb_q       <= '0;
							state_q    <= ST_OUT;
						end else begin
							out_pix_q <= 1'b1;
							pix_x_q   <= cur_col_q;
							pix_y_q   <= cur_row_q[ROW_AW-1:0];
							state_q   <= ST_P1;
						end
					end
				end
				ST_DET1: state_q <= ST_DET2;
				ST_DET2: begin
					det_q     <= psum;
					cur_row_q <= '0;
					cur_col_q <= '0;
					clr_q     <= '0;
					if (psum == '0 || rows == '0) begin
						emit_done_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + CNT_W'(1);
					if (clr_q == rows - CNT_W'(1)) begin
						edge_sel_q <= '0;
						state_q    <= ST_ELOAD;
					end
				end
				ST_ELOAD: state_q <= ST_ERD;
				ST_ERD, ST_EWR: begin
					if (state_q == ST_ERD && y_ok) begin
						state_q <= ST_EWR;
					end else if (epos.last) begin
						if (edge_sel_q == 2'd2) begin
							seek_row_q   <= '0;
							seek_first_q <= 1'b1;
							seek_pix_q   <= 1'b0;
							state_q      <= ST_SKRD;
						end else begin
							edge_sel_q <= edge_sel_q + 2'd1;
							state_q    <= ST_ELOAD;
						end
					end else begin
						state_q <= ST_ERD;
					end
				end
				ST_SKRD: begin
					if (seek_row_q >= rows) begin
						emit_done_q <= 1'b1;
						out_last_q  <= 1'b1;
						state_q     <= seek_pix_q ? ST_OUT : ST_IDLE;
					end else begin
						state_q <= ST_SKCHK;
					end
				end
				ST_SKCHK: begin
					if (sk_hit) begin
						cur_row_q   <= seek_row_q;
						cur_col_q   <= c_eff[COORD_BITS-1:0];
						cur_right_q <= rd_right;
						emit_done_q <= 1'b0;
						out_last_q  <= 1'b0;
						state_q     <= seek_pix_q ? ST_OUT : ST_IDLE;
					end else begin
						seek_row_q   <= seek_row_q + CNT_W'(1);
						seek_first_q <= 1'b1;
						state_q      <= ST_SKRD;
					end
				end
				ST_P1: state_q <= ST_P2;
				ST_P2: begin
					p1_q    <= psum;
					state_q <= ST_P3;
				end
				ST_P3: begin
					p2_q    <= psum;
					state_q <= ST_DIVS;
				end
				ST_DIVS: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (!busy_a && !busy_b) begin
						wa_q <= qa;
						wb_q <= qb;
						if (nx <= CW'(cur_right_q)) begin
							cur_col_q  <= nx[COORD_BITS-1:0];
							out_last_q <= 1'b0;
							state_q    <= ST_OUT;
						end else begin
							seek_row_q   <= cur_row_q + CNT_W'(1);
							seek_col_q   <= nx;
							seek_first_q <= 1'b1;
							seek_pix_q   <= 1'b1;
							state_q      <= ST_SKRD;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {7'd0, wc, wb_q, wa_q, pix_y_q, pix_x_q};
						m_tuser  <= out_pix_q;
						m_tlast  <= out_last_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`include "assert_macros.svh"

	`ASSERT_IMP(a_ram_we_state, ram_we, state_q == ST_CLEAR || state_q == ST_EWR)
	`ASSERT_IMP(a_empty_beat_zero, m_tvalid && !m_tuser, m_tdata == '0 && !m_tlast)
	`ASSERT_IMP(a_live_needs_det, state_q == ST_IDLE && !emit_done_q, det_q != '0)
	`ASSERT_NXT(a_out_loads, state_q == ST_OUT && out_free, m_tvalid && state_q == ST_IDLE)
endmodule

// ----- bench/triangle_span_barycentric_raster_test.sv -----
// Self-checking bench for the triangle span rasterizer: table plus random triangles
`timescale 1ns / 1ps

module triangle_span_barycentric_raster_test;
	import tsbr_pkg::*;

	localparam longint CYCLE_LIMIT = 64'd8000000;
	localparam longint UNIT = 64'd65536;
	localparam longint NO_COL = -64'sd1 <<< 40;

	typedef struct {
		bit          ok;
		logic [11:0] x;
		logic [9:0]  y;
		logic [16:0] wa;
		logic [16:0] wb;
		logic [16:0] wc;
		bit          last;
	} pixel_t;

	typedef struct {
		logic   cmd;
		int     c[6];
		bit     typed;
		pixel_t want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic        cfg_index;
	logic [10:0] cfg_data;

	triangle_span_barycentric_raster uut (.*);

	// predictor state
	int unsigned width_reg = 640;
	int unsigned height_reg = 480;
	int          span_l[MAX_ROWS];
	int          span_r[MAX_ROWS];
	longint      vx[3];
	longint      vy[3];
	longint      det;
	longint      row_at;
	longint      col_at;
	bit          drained = 1;

	pixel_t      pending_px[$];
	row_t        table_rows[$];
	int          errors = 0;
	int          burst_left = 0;
	int          beats = 0;
	bit          hold_req = 0;
	longint      cycles = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic longint row_count();
		return (height_reg > MAX_ROWS) ? MAX_ROWS : height_reg;
	endfunction

	function automatic void widen_row(longint x, longint y);
		if (y < 0 || y >= row_count())
			return;
		if (x < span_l[y]) span_l[y] = int'(x);
		if (x > span_r[y]) span_r[y] = int'(x);
	endfunction

	function automatic void trace_edge(longint x0, longint y0, longint x1, longint y1);
		longint dx, dy, sx, sy, err, e2;
		dx = (x1 > x0) ? x1 - x0 : x0 - x1;
		dy = (y1 > y0) ? y0 - y1 : y1 - y0;
		sx = (x0 < x1) ? 1 : -1;
		sy = (y0 < y1) ? 1 : -1;
		err = dx + dy;
		forever begin
			widen_row(x0, y0);
			if (x0 == x1 && y0 == y1)
				break;
			e2 = 2 * err;
			if (e2 >= dy) begin
				err += dy;
				x0 += sx;
			end
			if (e2 <= dx) begin
				err += dx;
				y0 += sy;
			end
		end
	endfunction

	function automatic bit seek_pixel(longint r, longint c);
		longint n;
		n = row_count();
		while (r >= 0 && r < n) begin
			if (span_l[r] <= span_r[r]) begin
				if (c < span_l[r]) c = span_l[r];
				if (c <= span_r[r]) begin
					row_at = r;
					col_at = c;
					return 1;
				end
			end
			r++;
			c = NO_COL;
		end
		return 0;
	endfunction

	function automatic longint frac_weight(longint p);
		longint q;
		q = (p * UNIT) / det;
		if (q < 0) q = 0;
		if (q > UNIT) q = UNIT;
		return q;
	endfunction

	// advance the predictor by one beat; returns 1 when a result is due
	function automatic bit raster_step(logic cmd, int c[6], output pixel_t px);
		longint x, y, p1, p2, wa, wb, wc;
		px = '{default: 0};
		if (cmd == CMD_START) begin
			for (int i = 0; i < 3; i++) begin
				vx[i] = longint'($signed(c[2*i][11:0]));
				vy[i] = longint'($signed(c[2*i+1][11:0]));
			end
			det = (vy[1] - vy[2]) * (vx[0] - vx[2]) + (vx[2] - vx[1]) * (vy[0] - vy[2]);
			for (int r = 0; r < row_count(); r++) begin
				span_l[r] = int'(width_reg);
				span_r[r] = 0;
			end
			trace_edge(vx[0], vy[0], vx[2], vy[2]);
			trace_edge(vx[0], vy[0], vx[1], vy[1]);
			trace_edge(vx[1], vy[1], vx[2], vy[2]);
			row_at = 0;
			col_at = 0;
			drained = (det == 0) || !seek_pixel(0, NO_COL);
			return 0;
		end
		if (drained)
			return 1;
		x = col_at;
		y = row_at;
		p1 = (vy[1] - vy[2]) * (x - vx[2]) + (vx[2] - vx[1]) * (y - vy[2]);
		p2 = (vy[2] - vy[0]) * (x - vx[2]) + (vx[0] - vx[2]) * (y - vy[2]);
		wa = frac_weight(p1);
		wb = frac_weight(p2);
		wc = UNIT - wa - wb;
		if (wc < 0) wc = 0;
		if (wc > UNIT) wc = UNIT;
		px.ok = 1;
		px.x = x[11:0];
		px.y = y[9:0];
		px.wa = wa[16:0];
		px.wb = wb[16:0];
		px.wc = wc[16:0];
		if (!seek_pixel(y, x + 1)) begin
			drained = 1;
			px.last = 1;
		end
		return 1;
	endfunction

	// receiver: random stall pattern from four modes, plus a long hold on request
	initial begin
		int mode;
		m_tready = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 0;
				repeat (600) @(negedge clk);
				hold_req = 0;
			end
			if (cycles % 64 == 0) mode = $urandom_range(0, 3);
			case (mode)
				0: m_tready <= 1;
				1: m_tready <= $urandom_range(0, 1);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_px.size() == 0) begin
				$display("%0t: beat with nothing expected: data %h user %b last %b",
					$time, m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				want = pending_px.pop_front();
				if (m_tuser !== want.ok || m_tdata[11:0] !== want.x
						|| m_tdata[21:12] !== want.y || m_tdata[38:22] !== want.wa
						|| m_tdata[55:39] !== want.wb || m_tdata[72:56] !== want.wc
						|| m_tlast !== want.last || m_tdata[79:73] !== 7'd0) begin
					$display("%0t: mismatch exp ok=%b x=%0d y=%0d a=%0d b=%0d c=%0d last=%b",
						$time, want.ok, $signed(want.x), want.y, want.wa, want.wb,
						want.wc, want.last);
					$display("%0t:          act ok=%b x=%0d y=%0d a=%0d b=%0d c=%0d last=%b",
						$time, m_tuser, $signed(m_tdata[11:0]), m_tdata[21:12],
						m_tdata[38:22], m_tdata[55:39], m_tdata[72:56], m_tlast);
					errors++;
				end
			end
		end
	end

	task automatic send_beat(logic cmd, int c[6], bit typed, pixel_t typed_px);
		int gap;
		pixel_t px;
		logic [71:0] d;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		for (int i = 0; i < 6; i++)
			d[12*i +: 12] = c[i][11:0];
		@(negedge clk);
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		beats++;
		if (raster_step(cmd, c, px))
			pending_px.push_back(typed ? typed_px : px);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 0;
		burst_left = 0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, int unsigned val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val[10:0];
		@(negedge clk);
		cfg_we <= 0;
		if (idx == CFG_WIDTH) width_reg = val & 11'h7FF;
		else height_reg = val & 11'h7FF;
	endtask

	function automatic void add_row(logic cmd, int a, int b, int cc, int d, int e, int f,
			bit typed);
		row_t r;
		r.cmd = cmd;
		r.c = '{a, b, cc, d, e, f};
		r.typed = typed;
		r.want = '{default: 0};
		table_rows.push_back(r);
	endfunction

	task automatic next_beat();
		int z[6];
		pixel_t none;
		z = '{0, 0, 0, 0, 0, 0};
		none = '{default: 0};
		send_beat(CMD_NEXT, z, 0, none);
	endtask

	function automatic int coord_full();
		return $signed(12'($urandom()));
	endfunction

	task automatic random_triangle();
		int c[6];
		int sz, ox, oy, sel, n;
		pixel_t none;
		none = '{default: 0};
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			next_beat();
			return;
		end
		if (sel < 11) begin
			foreach (c[i]) c[i] = coord_full();
		end else if (sel < 16) begin
			// collinear points
			ox = $urandom_range(0, 40) - 10;
			oy = $urandom_range(0, 40) - 10;
			sz = $urandom_range(0, 6);
			c = '{ox, oy, ox + sz, oy + 2 * sz, ox + 2 * sz, oy + 4 * sz};
		end else begin
			sz = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 7);
			ox = $urandom_range(0, 60) - 15;
			oy = ($urandom_range(0, 3) == 0) ? int'(height_reg) - $urandom_range(0, 10)
				: $urandom_range(0, 40) - 8;
			if ($urandom_range(0, 5) == 0) ox = int'(width_reg) - $urandom_range(0, 6);
			foreach (c[i])
				c[i] = ((i % 2) ? oy : ox) + $urandom_range(0, sz);
		end
		send_beat(CMD_START, c, 0, none);
		if ($urandom_range(0, 1) == 0) begin
			n = 0;
			while (!drained && n < 80) begin
				next_beat();
				n++;
			end
			if ($urandom_range(0, 1) == 0) next_beat();
		end else begin
			repeat ($urandom_range(1, 20)) next_beat();
		end
	endtask

	initial begin
		int phase_w[6];
		int phase_h[6];
		int start_at;
		bit mid_done;
		int zc[6];
		pixel_t none;
		s_tvalid = 0;
		s_tuser = 0;
		s_tdata = '0;
		cfg_we = 0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		zc = '{0, 0, 0, 0, 0, 0};
		none = '{default: 0};
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed table
		add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 1);
		add_row(CMD_START, 5, 5, 5, 5, 5, 5, 0);
		add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 1);
		add_row(CMD_START, -2048, -2048, 2047, -2048, -2048, 2047, 0);
		add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_START, 2047, 2047, -2048, 2047, 2047, -2048, 0);
		add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_START, -5, -9, 4, -20, -30, -3, 0);
		add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 1);
		add_row(CMD_START, 0, 0, 3, 0, 0, 3, 0);
		repeat (10) add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 1);
		add_row(CMD_START, 700, 2, 660, 5, 650, 0, 0);
		add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0);
		foreach (table_rows[i])
			send_beat(table_rows[i].cmd, table_rows[i].c, table_rows[i].typed,
				table_rows[i].want);

		// long receiver hold while the sender keeps offering beats
		hold_req = 1;
		repeat (12) next_beat();
		drain();

		phase_w = '{640, 2047, 0, 1, 1024, 100};
		phase_h = '{480, 2047, 0, 1, 1024, 37};
		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				write_cfg(CFG_WIDTH, phase_w[p]);
				write_cfg(CFG_HEIGHT, phase_h[p]);
			end
			start_at = beats;
			mid_done = 0;
			while (beats - start_at < 315) begin
				random_triangle();
				if (p == 1 && !mid_done && beats - start_at >= 160) begin
					drain();
					mid_done = 1;
				end
			end
			next_beat();
			// retire the open triangle before the screen size changes
			send_beat(CMD_START, zc, 0, none);
			drain();
		end

		if (errors == 0 && pending_px.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
